/* hw/rtl/qrs_pkg.sv */
`timescale 1ns / 1ps
package qrs_pkg;
   localparam int DefFracBits = 16;
   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_LINEAR  = 2'd1;
   localparam logic [1:0] KIND_REAL    = 2'd2;
   localparam logic [1:0] KIND_COMPLEX = 2'd3;

   typedef struct packed {
      logic signed [31:0] coef_a;
      logic signed [31:0] coef_b;
      logic signed [31:0] coef_c;
   } req_type;

   typedef struct packed {
      logic [1:0]         root_kind;
      logic signed [31:0] first_value;
      logic signed [31:0] second_value;
      logic               overflow;
   } rsp_type;

   // classified job handed from front to back
   typedef struct packed {
      logic [1:0]         kind;
      logic signed [32:0] num1;
      logic signed [32:0] num2;
      logic signed [32:0] den;
      logic [65:0]        dmag;
   } job_type;
endpackage

/* hw/rtl/quadratic_root_solver_unit.sv */
`timescale 1ns / 1ps
// quadratic root solver: coefficients a, b, c in signed fixed point in,
// classified roots out.
// req channel: valid/ready, one coefficient triple per item.
// rsp channel: valid/ready, one result item per request item, in order.
// throughput: one item per cycle when the receiver keeps rsp_ready high.
// stages: 2 front stages, the queue, 35 square root stages,
// 36 + FRAC_BITS divider stages and one output register; the root and
// divide pipelines resolve one bit per stage.
// the front computes b*b and a*c and classifies the item; the back runs
// the root and both divisions in lockstep.
// a stall on rsp_ready freezes the back pipeline; the four-entry queue
// absorbs the front, then req_ready falls.
// synchronous reset empties every stage and the queue; no results are
// pending after reset.
module quadratic_root_solver_unit #(
   parameter int FRAC_BITS = qrs_pkg::DefFracBits
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qrs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qrs_pkg::rsp_type rsp_data
);
   import qrs_pkg::*;

   logic    f_valid, f_ready, q_valid, q_ready;
   job_type f_job, q_job;

   qrs_front u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_item(req_data),
      .out_valid(f_valid), .out_ready(f_ready), .out_job(f_job)
   );

   qrs_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
   );

   qrs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_job(q_job),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_item(rsp_data)
   );

`ifndef SYNTHESIS
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.root_kind == KIND_NONE |->
      rsp_data.first_value == 0 && rsp_data.second_value == 0 && !rsp_data.overflow)
      else $error("no-solution item carries values");
   a_linear_second: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.root_kind == KIND_LINEAR |-> rsp_data.second_value == 0)
      else $error("linear item has second value");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");
`endif
endmodule

/* hw/rtl/qrs_front.sv */
`timescale 1ns / 1ps
module qrs_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  qrs_pkg::req_type in_item,
   output logic             out_valid,
   input  logic             out_ready,
   output qrs_pkg::job_type out_job
);
   import qrs_pkg::*;

   // stage 1: products
   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_kind_ff;
   logic signed [32:0] s1_b_ff, s1_c_ff, s1_a_ff;
   logic [63:0] s1_bb_ff, s1_p_ff;
   logic        s1_same_ff;
   logic [31:0] ua, ub, uc;

   // stage 2: classified job
   logic    s2_valid_ff;
   job_type s2_job_ff, s2_job_in;
   logic    adv2, adv1;

   assign adv2 = !s2_valid_ff || out_ready;
   assign adv1 = !s1_valid_ff || adv2;
   assign in_ready = adv1;
   assign s1_valid_in = in_valid;

   assign ua = in_item.coef_a[31] ? 32'(-in_item.coef_a) : in_item.coef_a;
   assign ub = in_item.coef_b[31] ? 32'(-in_item.coef_b) : in_item.coef_b;
   assign uc = in_item.coef_c[31] ? 32'(-in_item.coef_c) : in_item.coef_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= s1_valid_in;
      end
      if (adv1) begin
         s1_a_ff  <= 33'(in_item.coef_a);
         s1_b_ff  <= 33'(in_item.coef_b);
         s1_c_ff  <= 33'(in_item.coef_c);
         s1_bb_ff <= 64'(ub) * 64'(ub);
         s1_p_ff  <= 64'(ua) * 64'(uc);
         s1_same_ff <= in_item.coef_a[31] == in_item.coef_c[31];
         if (in_item.coef_a == 0 && in_item.coef_b == 0) begin
            s1_kind_ff <= KIND_NONE;
         end else if (in_item.coef_a == 0) begin
            s1_kind_ff <= KIND_LINEAR;
         end else begin
            s1_kind_ff <= KIND_REAL;
         end
      end
   end

   logic [65:0] four_p, bb66;
   assign four_p = {s1_p_ff, 2'b00};
   assign bb66   = {2'b00, s1_bb_ff};

   always_comb begin
      s2_job_in      = '0;
      s2_job_in.kind = s1_kind_ff;
      s2_job_in.den  = 33'(s1_a_ff <<< 1);
      s2_job_in.num1 = -s1_b_ff;
      s2_job_in.num2 = -s1_b_ff;
      if (s1_kind_ff == KIND_LINEAR) begin
         s2_job_in.num1 = -s1_c_ff;
         s2_job_in.num2 = '0;
         s2_job_in.den  = s1_b_ff;
      end else if (s1_kind_ff == KIND_REAL) begin
         if (s1_p_ff == 0 || !s1_same_ff) begin
            s2_job_in.dmag = bb66 + four_p;
         end else if (four_p <= bb66) begin
            s2_job_in.dmag = bb66 - four_p;
         end else begin
            s2_job_in.dmag = four_p - bb66;
            s2_job_in.kind = KIND_COMPLEX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv2) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv2) begin
         s2_job_ff <= s2_job_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_job   = s2_job_ff;
endmodule

/* hw/rtl/qrs_queue.sv */
`timescale 1ns / 1ps
module qrs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  qrs_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output qrs_pkg::job_type out_job
);
   import qrs_pkg::*;

   job_type    mem_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = cnt_ff != 3'd4;
   assign out_valid = cnt_ff != 3'd0;
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign out_job = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 2'd1;
         if (pop) rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
      if (push) mem_ff[wr_ff] <= in_job;
   end
endmodule

/* hw/rtl/qrs_back.sv */
`timescale 1ns / 1ps
module qrs_back #(
   parameter int FRAC_BITS = qrs_pkg::DefFracBits
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  qrs_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output qrs_pkg::rsp_type out_item
);
   import qrs_pkg::*;

   // sqrt: 34 stages, one result bit each; then two divides in parallel
   localparam int SqBits = 34;
   localparam int NumW   = 35 + FRAC_BITS;   // magnitude of scaled numerator
   localparam int QW     = NumW;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [32:0] num1;
      logic signed [32:0] num2;
      logic signed [32:0] den;
   } ctl_type;

   logic adv;
   logic out_valid_ff;
   rsp_type out_ff, out_in;
   assign adv = !out_valid_ff || out_ready;
   assign in_ready = adv;

   // square root pipeline
   logic        sv_ff [SqBits+1];
   ctl_type     sc_ff [SqBits+1];
   logic [65:0] srem_ff [SqBits+1];
   logic [33:0] sroot_ff [SqBits+1];

   always_ff @(posedge clock) begin
      if (reset) sv_ff[0] <= 1'b0;
      else if (adv) sv_ff[0] <= in_valid;
      if (adv) begin
         sc_ff[0]    <= '{in_job.kind, in_job.num1, in_job.num2, in_job.den};
         srem_ff[0]  <= in_job.dmag;
         sroot_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < SqBits; i++) begin : g_sq
      localparam int Bit = SqBits - 1 - i;
      logic [67:0] trial;
      logic [67:0] t34;
      // (r + 2^bit)^2 - r^2 = 2^(bit+1) r + 2^(2bit)
      assign t34   = 68'(sroot_ff[i]) << (Bit + 1);
      assign trial = t34 + (68'd1 << (2 * Bit));
      always_ff @(posedge clock) begin
         if (reset) sv_ff[i+1] <= 1'b0;
         else if (adv) sv_ff[i+1] <= sv_ff[i];
         if (adv) begin
            sc_ff[i+1] <= sc_ff[i];
            if (trial <= 68'(srem_ff[i])) begin
               srem_ff[i+1]  <= 66'(68'(srem_ff[i]) - trial);
               sroot_ff[i+1] <= sroot_ff[i] | (34'd1 << Bit);
            end else begin
               srem_ff[i+1]  <= srem_ff[i];
               sroot_ff[i+1] <= sroot_ff[i];
            end
         end
      end
   end

   // form numerators
   ctl_type c0;
   logic signed [34:0] s35, n1, n2;
   assign c0  = sc_ff[SqBits];
   assign s35 = 35'(sroot_ff[SqBits]);
   always_comb begin
      n1 = 35'(c0.num1);
      n2 = 35'(c0.num2);
      if (c0.kind == KIND_REAL) begin
         n1 = 35'(c0.num1) + s35;
         n2 = 35'(c0.num2) - s35;
      end else if (c0.kind == KIND_COMPLEX) begin
         n2 = s35;
      end
   end

   logic           dv_ff [QW+1];
   logic [1:0]     dk_ff [QW+1];
   logic [NumW-1:0] dn1_ff [QW+1], dn2_ff [QW+1];
   logic [NumW-1:0] dr1_ff [QW+1], dr2_ff [QW+1];
   logic [QW-1:0]  dq1_ff [QW+1], dq2_ff [QW+1];
   logic           dg1_ff [QW+1], dg2_ff [QW+1];
   logic [32:0]    dd_ff [QW+1];

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else if (adv) dv_ff[0] <= sv_ff[SqBits];
      if (adv) begin
         dk_ff[0]  <= c0.kind;
         dn1_ff[0] <= NumW'(n1[34] ? 35'(-n1) : n1) << FRAC_BITS;
         dn2_ff[0] <= NumW'(n2[34] ? 35'(-n2) : n2) << FRAC_BITS;
         dg1_ff[0] <= n1[34] ^ c0.den[32];
         dg2_ff[0] <= n2[34] ^ c0.den[32];
         dd_ff[0]  <= c0.den[32] ? 33'(-c0.den) : 33'(c0.den);
         dr1_ff[0] <= '0;
         dr2_ff[0] <= '0;
         dq1_ff[0] <= '0;
         dq2_ff[0] <= '0;
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_div
      localparam int Bit = QW - 1 - j;
      logic [NumW:0] r1, r2;
      assign r1 = {dr1_ff[j], dn1_ff[j][Bit]};
      assign r2 = {dr2_ff[j], dn2_ff[j][Bit]};
      always_ff @(posedge clock) begin
         if (reset) dv_ff[j+1] <= 1'b0;
         else if (adv) dv_ff[j+1] <= dv_ff[j];
         if (adv) begin
            dk_ff[j+1]  <= dk_ff[j];
            dn1_ff[j+1] <= dn1_ff[j];
            dn2_ff[j+1] <= dn2_ff[j];
            dg1_ff[j+1] <= dg1_ff[j];
            dg2_ff[j+1] <= dg2_ff[j];
            dd_ff[j+1]  <= dd_ff[j];
            if (r1 >= (NumW+1)'(dd_ff[j])) begin
               dr1_ff[j+1] <= NumW'(r1 - (NumW+1)'(dd_ff[j]));
               dq1_ff[j+1] <= dq1_ff[j] | (QW'(1) << Bit);
            end else begin
               dr1_ff[j+1] <= NumW'(r1);
               dq1_ff[j+1] <= dq1_ff[j];
            end
            if (r2 >= (NumW+1)'(dd_ff[j])) begin
               dr2_ff[j+1] <= NumW'(r2 - (NumW+1)'(dd_ff[j]));
               dq2_ff[j+1] <= dq2_ff[j] | (QW'(1) << Bit);
            end else begin
               dr2_ff[j+1] <= NumW'(r2);
               dq2_ff[j+1] <= dq2_ff[j];
            end
         end
      end
   end

   // sign and saturate a magnitude quotient
   function automatic logic [32:0] sat_fn(input logic [QW-1:0] q, input logic neg);
      logic [32:0] r;
      if (neg) begin
         if (q > QW'(33'h080000000)) r = {1'b1, 32'h80000000};
         else r = {1'b0, 32'(-q)};
      end else begin
         if (q > QW'(32'h7fffffff)) r = {1'b1, 32'h7fffffff};
         else r = {1'b0, q[31:0]};
      end
      return r;
   endfunction

   logic [32:0] sat1, sat2;
   logic [1:0]  fk;
   assign fk   = dk_ff[QW];
   assign sat1 = sat_fn(dq1_ff[QW], dg1_ff[QW]);
   assign sat2 = sat_fn(dq2_ff[QW], dg2_ff[QW]);

   always_comb begin
      out_in = '0;
      out_in.root_kind = fk;
      if (fk == KIND_LINEAR) begin
         out_in.first_value = sat1[31:0];
         out_in.overflow    = sat1[32];
      end else if (fk != KIND_NONE) begin
         out_in.first_value  = sat1[31:0];
         out_in.second_value = sat2[31:0];
         out_in.overflow     = sat1[32] | sat2[32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (adv) out_valid_ff <= dv_ff[QW];
      if (adv) out_ff <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;
endmodule

/* tb/quadratic_root_solver_checker.sv */
`timescale 1ns / 1ps
module quadratic_root_solver_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  qrs_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  qrs_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending_roots,
   output int               roots_seen,
   output int               kind_seen [4],
   output int               overflow_seen
);
   import qrs_pkg::*;

   localparam int FracBits = DefFracBits;

   rsp_type expected_roots [$];

   // floor of the square root of a 66 bit magnitude
   function automatic logic [33:0] root_floor(input logic [65:0] mag);
      logic [33:0] r;
      logic [33:0] t;
      logic [67:0] sq;
      r = '0;
      for (int i = 33; i >= 0; i--) begin
         t = r | (34'd1 << i);
         sq = t * t;
         if (sq <= {2'b00, mag}) r = t;
      end
      return r;
   endfunction

   // num * 2^FracBits / den, truncated toward zero, clamped to 32 bits
   function automatic logic signed [31:0] scaled_quotient(input logic signed [40:0] num,
         input logic signed [40:0] den, inout logic ovf);
      logic signed [80:0] q;
      q = ($signed({{40{num[40]}}, num}) <<< FracBits) / $signed({{40{den[40]}}, den});
      if (q > 81'sd2147483647) begin
         ovf = 1'b1;
         return 32'sh7fffffff;
      end
      if (q < -81'sd2147483648) begin
         ovf = 1'b1;
         return 32'sh80000000;
      end
      return q[31:0];
   endfunction

   function automatic rsp_type solve_roots(input req_type rq);
      rsp_type r;
      logic signed [67:0] a, b, c, disc;
      logic [65:0] dmag;
      logic signed [40:0] s, two_a;
      logic ovf;
      a = rq.coef_a;
      b = rq.coef_b;
      c = rq.coef_c;
      ovf = 1'b0;
      r = '0;
      if (a == 0 && b == 0) begin
         r.root_kind = KIND_NONE;
      end else if (a == 0) begin
         r.root_kind = KIND_LINEAR;
         r.first_value = scaled_quotient(-c[40:0], b[40:0], ovf);
      end else begin
         disc = b * b - 4 * a * c;
         dmag = disc < 0 ? -disc : disc;
         s = {7'd0, root_floor(dmag)};
         two_a = 2 * a[40:0];
         if (disc < 0) begin
            r.root_kind = KIND_COMPLEX;
            r.first_value = scaled_quotient(-b[40:0], two_a, ovf);
            r.second_value = scaled_quotient(s, two_a, ovf);
         end else begin
            r.root_kind = KIND_REAL;
            r.first_value = scaled_quotient(-b[40:0] + s, two_a, ovf);
            r.second_value = scaled_quotient(-b[40:0] - s, two_a, ovf);
         end
      end
      r.overflow = ovf;
      return r;
   endfunction

   assign pending_roots = expected_roots.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_roots.delete();
         error_count <= 0;
         roots_seen <= 0;
         overflow_seen <= 0;
         for (int k = 0; k < 4; k++) kind_seen[k] <= 0;
      end else begin
         if (req_valid && req_ready) expected_roots.push_back(solve_roots(req_data));
         if (rsp_valid && rsp_ready) begin
            roots_seen <= roots_seen + 1;
            kind_seen[rsp_data.root_kind] <= kind_seen[rsp_data.root_kind] + 1;
            if (rsp_data.overflow) overflow_seen <= overflow_seen + 1;
            if (expected_roots.size() == 0) begin
               if (error_count < 10) $display("unexpected result item %p", rsp_data);
               error_count <= error_count + 1;
            end else begin
               want = expected_roots.pop_front();
               if (want.root_kind !== rsp_data.root_kind
                     || want.first_value !== rsp_data.first_value
                     || want.second_value !== rsp_data.second_value
                     || want.overflow !== rsp_data.overflow) begin
                  if (error_count < 10)
                     $display("mismatch: expected kind %0d %0d %0d ovf %0d, got %0d %0d %0d ovf %0d",
                        want.root_kind, want.first_value, want.second_value, want.overflow,
                        rsp_data.root_kind, rsp_data.first_value, rsp_data.second_value,
                        rsp_data.overflow);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

/* tb/quadratic_root_solver_unit_tb.sv */
`timescale 1ns / 1ps
module quadratic_root_solver_unit_tb;
   import qrs_pkg::*;

   localparam int RandomItems = 1700;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      error_count;
   int      pending_roots;
   int      roots_seen;
   int      kind_seen [4];
   int      overflow_seen;
   bit      stall_on;

   quadratic_root_solver_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   quadratic_root_solver_checker check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .error_count(error_count), .pending_roots(pending_roots),
      .roots_seen(roots_seen), .kind_seen(kind_seen), .overflow_seen(overflow_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stalls in runs, with calm stretches where it never stalls
   initial begin
      int run;
      rsp_ready = 1'b0;
      forever begin
         run = $urandom_range(1, 40);
         stall_on = ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
         repeat (run) @(posedge clock) rsp_ready <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
   end

   function automatic logic signed [31:0] pick_coef();
      case ($urandom_range(0, 7))
         0: return 32'sh0;
         1: return 32'sh7fffffff;
         2: return 32'sh80000000;
         3: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
         4: return 32'sh00010000 * ($signed($urandom_range(0, 20)) - 10);
         default: return $urandom;
      endcase
   endfunction

   // hold the item until it is taken, leaving valid high for the next one when keep is set
   task automatic send_item(input req_type item, input bit keep);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (!keep) req_valid <= 1'b0;
   endtask

   initial begin
      req_type item;
      req_type directed [$];
      int burst;
      int left;
      int wait_cycles;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed.push_back('{32'sh0, 32'sh0, 32'sh12345});
      directed.push_back('{32'sh0, 32'sh00010000, 32'sh00030000});
      directed.push_back('{32'sh0, 32'sh1, 32'sh7fffffff});
      directed.push_back('{32'sh0, 32'sh80000000, 32'sh80000000});
      directed.push_back('{32'sh0, 32'shffffffff, 32'sh80000000});
      directed.push_back('{32'sh00010000, 32'shfffd0000, 32'sh00020000});
      directed.push_back('{32'sh00010000, 32'sh00020000, 32'sh00010000});
      directed.push_back('{32'sh00010000, 32'sh0, 32'sh00010000});
      directed.push_back('{32'shffff0000, 32'sh00020000, 32'shfffe0000});
      directed.push_back('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
      directed.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000});
      directed.push_back('{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff});
      directed.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh80000000});
      directed.push_back('{32'sh1, 32'sh0, 32'sh0});
      directed.push_back('{32'sh1, 32'sh7fffffff, 32'sh0});
      directed.push_back('{32'shffffffff, 32'sh80000000, 32'sh1});
      directed.push_back('{32'sh1, 32'sh1, 32'sh7fffffff});
      directed.push_back('{32'sh00010000, 32'sh0, 32'sh0});
      // the random bursts follow straight on, so valid stays high
      foreach (directed[i]) send_item(directed[i], 1'b1);
      left = RandomItems;
      while (left > 0) begin
         burst = $urandom_range(1, 30);
         for (int i = 0; i < burst && left > 0; i++) begin
            item.coef_a = ($urandom_range(0, 9) == 0) ? 32'sh0 : pick_coef();
            item.coef_b = pick_coef();
            item.coef_c = pick_coef();
            left--;
            send_item(item, i != burst - 1 && left > 0);
         end
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      wait_cycles = 0;
      while (pending_roots != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (120) @(posedge clock);
      $display("%0d result items checked: %0d none, %0d linear, %0d real, %0d complex",
         roots_seen, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
      $display("%0d of them saturated", overflow_seen);
      if (error_count == 0 && pending_roots == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end
endmodule
